/* sv/saa_pkg.sv */
// Shared types and constants for the subnet address allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package saa_pkg;

    localparam int HOST_BITS_DEF = 8;
    localparam int WORD_LOG_MAX  = 5;

    localparam int ADDR_W    = 32;
    localparam int HB_W      = 4;
    localparam int ST_W      = 3;
    localparam int FC_W      = 9;
    localparam int IN_W      = 32;
    localparam int IN_USER_W = 8;
    localparam int OUT_W     = 48;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_OTHER   = 3'd1;
    localparam logic [ST_W-1:0] ST_INVALID = 3'd2;
    localparam logic [ST_W-1:0] ST_NONE    = 3'd3;
    localparam logic [ST_W-1:0] ST_DOUBLE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_NETWORK_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOST_BITS    = 1'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_start;
        logic clr_write;
        logic load_item;
        logic rd_en;
        logic eval;
        logic load_out;
    } saa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic in_skip;
        logic is_free;
        logic found;
        logic at_last;
        logic out_free;
    } saa_stat_t;

endpackage

`default_nettype wire

/* sv/subnet_address_allocator_top.sv */
// Top level of the subnet address allocator: controller, datapath, checks.
// Depends on saa_pkg, saa_ctrl, saa_datapath and saa_ram.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps one used bit per host of a subnet in a RAM of 32-bit rows
// (fewer bits per row when HOST_BITS is under 5) and handles one item at a time.
// After reset and after every register write it runs a clearing pass over every
// RAM row (8 rows for HOST_BITS = 8, 2**(HOST_BITS-5) in general, at least 2)
// during which no item is accepted. An allocate reads and tests map rows from the
// row of its start host on until a free bit or the last row; a free reads and
// updates the row of its host, and a free outside the subnet skips the map. The
// search reads each row through the RAM's registered read port, then tests it.
// A result waits in the output register until taken.
module subnet_address_allocator_top #(
    parameter int HOST_BITS = saa_pkg::HOST_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] req_address
    input  wire logic [saa_pkg::IN_W-1:0]      s_tdata,
    // [0] func, [1] has_request, [7:2] zero
    input  wire logic [saa_pkg::IN_USER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [2:0] status, [34:3] given_address, [43:35] free_count, [47:44] zero
    output logic      [saa_pkg::OUT_W-1:0]     m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [saa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [saa_pkg::CFG_W-1:0]     cfg_wdata
);

    import saa_pkg::*;

    saa_cmd_t  cmd;
    saa_stat_t st;

    saa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_wr_en (cfg_wr_en),
        .st        (st),
        .cmd       (cmd)
    );

    saa_datapath #(
        .HOST_BITS (HOST_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st)
    );

    // Only one item is in the block at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // A register write starts the clearing pass, which blocks input.
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !s_tready)
        else $error("input ready right after a register write");

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // The status code of a result is always a defined code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[ST_W-1:0] <= ST_DOUBLE))
        else $error("undefined status code on output");

endmodule

`default_nettype wire

/* sv/saa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the used map rows of the allocator.
`timescale 1ns / 1ps
`default_nettype none

module saa_ram #(
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 3
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [1 << ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/saa_ctrl.sv */
// Controller state machine of the subnet address allocator.
// Depends on saa_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module saa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               cfg_wr_en,
    input  wire saa_pkg::saa_stat_t st,
    output saa_pkg::saa_cmd_t       cmd
);

    import saa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = st.in_skip ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (st.is_free || st.found || st.at_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        // A register write reinitializes the map, restarting any pass under way.
        if (cfg_wr_en)
        begin
            cmd           = '0;
            cmd.clr_start = 1'b1;
            state_next    = S_CLEAR;
        end
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

`default_nettype wire

/* sv/saa_datapath.sv */
// Datapath of the subnet address allocator: registers, used map RAM, row scan
// and find-first logic, and the output register. Depends on saa_pkg and saa_ram.
`timescale 1ns / 1ps
`default_nettype none

module saa_datapath #(
    parameter int HOST_BITS = saa_pkg::HOST_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [saa_pkg::IN_W-1:0]         s_tdata,
    input  wire logic [saa_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [saa_pkg::OUT_W-1:0]        m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [saa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [saa_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire saa_pkg::saa_cmd_t                cmd,
    output saa_pkg::saa_stat_t                    st
);

    import saa_pkg::*;

    localparam int WORD_LOG = (HOST_BITS < WORD_LOG_MAX) ? HOST_BITS : WORD_LOG_MAX;
    localparam int W        = 1 << WORD_LOG;
    localparam int ROWS_LOG = HOST_BITS - WORD_LOG;
    localparam int ROW_W    = (ROWS_LOG > 0) ? ROWS_LOG : 1;
    localparam int CNT_W    = HOST_BITS + 1;
    localparam int EXT_W    = (CNT_W > FC_W) ? CNT_W : FC_W;

    // Configuration registers.
    logic [ADDR_W-1:0] base_reg;
    logic [HB_W-1:0]   hb_reg;

    // Item and scan registers.
    logic                 op_reg;
    logic                 invalid_reg;
    logic                 first_reg;
    logic [HOST_BITS-1:0] start_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [CNT_W-1:0]     used_total_reg;
    logic [ST_W-1:0]      status_reg;
    logic [ADDR_W-1:0]    given_reg;

    // Output register.
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;

    // Pool geometry from the host bits register.
    logic [4:0]           eff_bits;
    logic [CNT_W-1:0]     pool_size;
    logic [HOST_BITS-1:0] hm;
    logic [ADDR_W-1:0]    mask32;
    logic [ADDR_W-1:0]    base_net;
    logic [ROW_W-1:0]     last_row;
    logic [WORD_LOG-1:0]  hm_lo;

    always_comb
    begin
        if (hb_reg < HB_W'(2))
        begin
            eff_bits = 5'd2;
        end
        else if ({1'b0, hb_reg} > 5'(HOST_BITS))
        begin
            eff_bits = 5'(HOST_BITS);
        end
        else
        begin
            eff_bits = {1'b0, hb_reg};
        end
    end

    assign pool_size = CNT_W'(1) << eff_bits;
    assign hm        = HOST_BITS'(pool_size - CNT_W'(1));
    assign mask32    = ADDR_W'(hm);
    assign base_net  = base_reg & ~mask32;
    assign last_row  = ROW_W'(hm >> WORD_LOG);
    assign hm_lo     = hm[WORD_LOG-1:0];

    // Incoming item fields.
    logic                 in_func;
    logic                 in_req;
    logic [ADDR_W-1:0]    in_addr;
    logic                 in_net;
    logic [HOST_BITS-1:0] in_host;
    logic [HOST_BITS-1:0] in_start;

    assign in_func  = s_tuser[0];
    assign in_req   = s_tuser[1];
    assign in_addr  = s_tdata;
    assign in_net   = (in_addr & ~mask32) == base_net;
    assign in_host  = HOST_BITS'(in_addr & mask32);
    assign in_start = (in_func || (in_req && in_net)) ? in_host : '0;

    // Row evaluation on the word read from the map.
    logic [W-1:0]         rd_data;
    logic [W-1:0]         used_vec;
    logic [W-1:0]         free_vec;
    logic [WORD_LOG-1:0]  pos;
    logic                 found;
    logic                 at_last;
    logic [HOST_BITS-1:0] cur_host;
    logic [WORD_LOG-1:0]  start_lo;
    logic                 bit_set;
    logic [W-1:0]         init_row;

    assign start_lo = start_reg[WORD_LOG-1:0];
    assign at_last  = (row_reg == last_row);

    always_comb
    begin
        for (int j = 0; j < W; j++)
        begin
            // Bits below the start of the first row and past the pool end count as used.
            used_vec[j] = rd_data[j]
                        | (first_reg && (WORD_LOG'(j) < start_lo))
                        | (at_last && (WORD_LOG'(j) > hm_lo));
        end
    end

    assign free_vec = ~used_vec;
    assign found    = |free_vec;

    always_comb
    begin
        pos = '0;
        for (int j = W - 1; j >= 0; j--)
        begin
            if (free_vec[j])
            begin
                pos = WORD_LOG'(j);
            end
        end
    end

    assign cur_host = HOST_BITS'({row_reg, pos});
    assign bit_set  = rd_data[start_lo];

    always_comb
    begin
        init_row = '0;
        if (row_reg == '0)
        begin
            init_row[0] = 1'b1;
        end
        if (row_reg == last_row)
        begin
            init_row[hm_lo]                 = 1'b1;
            init_row[hm_lo - WORD_LOG'(1)]  = 1'b1;
        end
    end

    // Map RAM port control.
    logic         ram_we;
    logic [W-1:0] ram_wdata;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = init_row;
        if (cmd.clr_write)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.eval)
        begin
            if (op_reg)
            begin
                ram_we    = bit_set;
                ram_wdata = rd_data & ~(W'(1) << start_lo);
            end
            else
            begin
                ram_we    = found;
                ram_wdata = rd_data | (W'(1) << pos);
            end
        end
    end

    saa_ram #(
        .WIDTH  (W),
        .ADDR_W (ROW_W)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (row_reg),
        .rdata (rd_data)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 32'hC0A8_0000;
            hb_reg   <= HB_W'(8);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_NETWORK_BASE: base_reg <= cfg_wdata;
                REG_HOST_BITS:    hb_reg   <= cfg_wdata[HB_W-1:0];
                default:          base_reg <= base_reg;
            endcase
        end
    end

    // Control-side registers: scan row, used count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            used_total_reg <= CNT_W'(3);
        end
        else if (cmd.clr_start)
        begin
            row_reg        <= '0;
            used_total_reg <= CNT_W'(3);
        end
        else if (cmd.clr_write)
        begin
            row_reg <= row_reg + ROW_W'(1);
        end
        else if (cmd.load_item)
        begin
            row_reg <= ROW_W'(in_start >> WORD_LOG);
        end
        else if (cmd.eval)
        begin
            if (op_reg)
            begin
                if (bit_set)
                begin
                    used_total_reg <= used_total_reg - CNT_W'(1);
                end
            end
            else if (found)
            begin
                used_total_reg <= used_total_reg + CNT_W'(1);
            end
            else if (!at_last)
            begin
                row_reg <= row_reg + ROW_W'(1);
            end
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg      <= in_func;
            invalid_reg <= !in_func && in_req && !in_net;
            first_reg   <= 1'b1;
            start_reg   <= in_start;
            status_reg  <= ST_INVALID;
            given_reg   <= '0;
        end
        else if (cmd.eval)
        begin
            first_reg <= 1'b0;
            if (op_reg)
            begin
                status_reg <= bit_set ? ST_OK : ST_DOUBLE;
            end
            else if (found)
            begin
                given_reg <= base_net | ADDR_W'(cur_host);
                if (invalid_reg)
                begin
                    status_reg <= ST_INVALID;
                end
                else if (cur_host == start_reg)
                begin
                    status_reg <= ST_OK;
                end
                else
                begin
                    status_reg <= ST_OTHER;
                end
            end
            else if (at_last)
            begin
                given_reg  <= base_net + mask32 + ADDR_W'(1);
                status_reg <= ST_NONE;
            end
        end
    end

    // Output register.
    logic [EXT_W-1:0] free_ext;
    logic [FC_W-1:0]  free_count;

    assign free_ext   = EXT_W'(pool_size) - EXT_W'(used_total_reg);
    assign free_count = free_ext[FC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            m_data_reg <= {(OUT_W - FC_W - ADDR_W - ST_W)'(0), free_count, given_reg, status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign st.clr_last = &row_reg;
    assign st.in_skip  = in_func && !in_net;
    assign st.is_free  = op_reg;
    assign st.found    = found;
    assign st.at_last  = at_last;
    assign st.out_free = !m_valid_reg || m_tready;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for subnet_address_allocator_top: allocate and free items
// are checked against a bitmap model of the address pool, with random idling.
// Depends on saa_pkg and on the allocator RTL.
`timescale 1ns / 1ps

module testbench;
    import saa_pkg::*;

    localparam int POOL_DEPTH = 1 << HOST_BITS_DEF;
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE = 1'b1;
    localparam int MAX_GAP = 18;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [ADDR_W-1:0] DEFAULT_BASE = 32'hC0A8_0000;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] given_address;
        logic [FC_W-1:0]   free_count;
    } grant_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [31:0] req_address
    logic [IN_W-1:0]      s_tdata = '0;
    // [0] func, [1] has_request, [7:2] zero
    logic [IN_USER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [2:0] status, [34:3] given_address, [43:35] free_count, [47:44] zero
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_NETWORK_BASE;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Mirror of the pool: used bits, count and the two registers.
    bit                pool_used [POOL_DEPTH];
    int unsigned       pool_used_total;
    logic [ADDR_W-1:0] pool_base_reg = DEFAULT_BASE;
    logic [HB_W-1:0]   pool_hbits_reg = 4'd8;

    grant_t pending_grants[$];
    int     mismatches = 0;
    int     src_gap_max = MAX_GAP;
    int     snk_gap_max = MAX_GAP;
    int     snk_hold_len = 0;

    subnet_address_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("[subnet_address_allocator_top] ERROR");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] host_mask();
        int unsigned eff;
        eff = pool_hbits_reg;
        if (eff < 2)
            eff = 2;
        if (eff > HOST_BITS_DEF)
            eff = HOST_BITS_DEF;
        return (32'd1 << eff) - 32'd1;
    endfunction

    function automatic void clear_pool_model();
        logic [ADDR_W-1:0] hm;
        hm = host_mask();
        foreach (pool_used[i])
            pool_used[i] = 1'b0;
        pool_used[0] = 1'b1;
        pool_used[hm] = 1'b1;
        pool_used[hm - 1] = 1'b1;
        pool_used_total = 3;
    endfunction

    // Applies one item to the pool mirror and returns the grant it produces.
    function automatic grant_t apply_pool_op(input logic func, input logic has_req,
                                             input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] hm;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] h;
        logic [ADDR_W-1:0] fc;
        logic              in_net;
        logic              found;
        grant_t            g;
        hm = host_mask();
        base = pool_base_reg & ~hm;
        in_net = (addr & ~hm) == base;
        g.given_address = '0;
        if (func == FUNC_ALLOC)
        begin
            start = (has_req && in_net) ? (addr & hm) : '0;
            h = start;
            found = 1'b0;
            while (!found && h <= hm)
            begin
                if (!pool_used[h])
                    found = 1'b1;
                else
                    h++;
            end
            if (found)
            begin
                pool_used[h] = 1'b1;
                pool_used_total++;
                g.given_address = base | h;
                if (has_req && !in_net)
                    g.status = ST_INVALID;
                else if (h == start)
                    g.status = ST_OK;
                else
                    g.status = ST_OTHER;
            end
            else
            begin
                // An exhausted pool reports the first address past it.
                g.given_address = base + hm + 32'd1;
                g.status = ST_NONE;
            end
        end
        else if (!in_net)
            g.status = ST_INVALID;
        else if (pool_used[addr & hm])
        begin
            pool_used[addr & hm] = 1'b0;
            pool_used_total--;
            g.status = ST_OK;
        end
        else
            g.status = ST_DOUBLE;
        fc = hm + 32'd1 - pool_used_total;
        g.free_count = fc[FC_W-1:0];
        return g;
    endfunction

    task automatic send_item(input logic func, input logic has_req,
                             input logic [ADDR_W-1:0] addr);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        s_tuser <= {6'b0, has_req, func};
        do
            @(posedge clk);
        while (!s_tready);
        pending_grants.push_back(apply_pool_op(func, has_req, addr));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Any register write reinitializes the pool, so the mirror is cleared too.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_NETWORK_BASE)
            pool_base_reg = value;
        else
            pool_hbits_reg = value[HB_W-1:0];
        clear_pool_model();
    endtask

    task automatic send_random_item();
        logic [ADDR_W-1:0] hm;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] h;
        logic              flag_a;
        logic              flag_b;
        int                pick;
        hm = host_mask();
        base = pool_base_reg & ~hm;
        addr = $urandom;
        flag_a = $urandom_range(0, 1);
        flag_b = $urandom_range(0, 1);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_item(FUNC_ALLOC, 1'b0, addr);
        else if (pick < 60)
            send_item(FUNC_ALLOC, 1'b1, base | (addr & hm));
        else if (pick < 88)
        begin
            // Mostly free hosts that are in use, so the pool keeps turning over.
            h = addr & hm;
            for (int i = 0; i < 8 && !pool_used[h]; i++)
                h = $urandom & hm;
            send_item(FUNC_FREE, flag_a, base | h);
        end
        else
            send_item(flag_a, flag_b, addr);
    endtask

    task automatic test_reset_state();
        send_item(FUNC_ALLOC, 1'b0, 32'hFFFF_FFFF);
        send_item(FUNC_ALLOC, 1'b1, DEFAULT_BASE | 32'd1);
        send_item(FUNC_ALLOC, 1'b1, DEFAULT_BASE | 32'd255);
        send_item(FUNC_ALLOC, 1'b1, 32'h0A00_0005);
        send_item(FUNC_FREE, 1'b0, DEFAULT_BASE | 32'd2);
        send_item(FUNC_FREE, 1'b0, DEFAULT_BASE | 32'd2);
        send_item(FUNC_FREE, 1'b0, DEFAULT_BASE | 32'd100);
        send_item(FUNC_FREE, 1'b0, 32'hFFFF_FFFF);
        send_item(FUNC_FREE, 1'b1, DEFAULT_BASE);
        send_item(FUNC_ALLOC, 1'b1, DEFAULT_BASE);
        send_item(FUNC_FREE, 1'b0, DEFAULT_BASE | 32'd255);
        send_item(FUNC_ALLOC, 1'b1, DEFAULT_BASE | 32'd255);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        // A host width below the minimum leaves a pool with a single free host.
        write_reg(REG_HOST_BITS, 32'hFFFF_FFF0);
        write_reg(REG_NETWORK_BASE, 32'hFFFF_FFFF);
        send_item(FUNC_ALLOC, 1'b0, 32'h0000_0000);
        send_item(FUNC_ALLOC, 1'b0, 32'h0000_0000);
        send_item(FUNC_ALLOC, 1'b1, 32'h0000_0000);
        send_item(FUNC_FREE, 1'b0, 32'hFFFF_FFFD);
        send_item(FUNC_ALLOC, 1'b1, 32'hFFFF_FFFF);
        write_reg(REG_HOST_BITS, 32'd15);
        write_reg(REG_NETWORK_BASE, 32'h0000_0000);
        send_item(FUNC_ALLOC, 1'b1, 32'h0000_0080);
        send_item(FUNC_ALLOC, 1'b1, 32'h0000_0100);
        wait_idle();
    endtask

    task automatic test_back_pressure();
        src_gap_max = 0;
        snk_hold_len = 200;
        repeat (24) send_item(FUNC_ALLOC, 1'b0, $urandom);
        wait_idle();
        src_gap_max = MAX_GAP;
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] base;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase % 4)
                0: base = $urandom;
                1: base = '1;
                2: base = '0;
                default: base = $urandom;
            endcase
            write_reg(REG_NETWORK_BASE, base);
            write_reg(REG_HOST_BITS, $urandom_range(0, 15));
            case (phase % 3)
                0:
                begin
                    src_gap_max = MAX_GAP;
                    snk_gap_max = MAX_GAP;
                end
                1:
                begin
                    src_gap_max = 0;
                    snk_gap_max = 0;
                end
                default:
                begin
                    src_gap_max = (phase % 2) ? 0 : MAX_GAP;
                    snk_gap_max = (phase % 2) ? MAX_GAP : 0;
                end
            endcase
            repeat (105) send_random_item();
        end
        wait_idle();
    endtask

    // Result sink: random stalls per item, plus an occasional long hold.
    initial
    begin
        int stall;
        forever
        begin
            if (snk_hold_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (snk_hold_len) @(posedge clk);
                snk_hold_len = 0;
            end
            stall = $urandom_range(0, snk_gap_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d address %h free %0d",
                             m_tdata[2:0], m_tdata[34:3], m_tdata[43:35]);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (m_tdata[2:0] !== want.status || m_tdata[34:3] !== want.given_address
                    || m_tdata[43:35] !== want.free_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch (status address free): expected %0d %h %0d, got %0d %h %0d",
                                 want.status, want.given_address, want.free_count,
                                 m_tdata[2:0], m_tdata[34:3], m_tdata[43:35]);
                end
            end
        end
    end

    initial
    begin
        clear_pool_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_config_extremes();
        test_back_pressure();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0)
            $display("[subnet_address_allocator_top] OK");
        else
            $display("[subnet_address_allocator_top] ERROR");
        $finish;
    end

endmodule

/* sim.f */
sv/saa_pkg.sv
sv/saa_ram.sv
sv/saa_ctrl.sv
sv/saa_datapath.sv
sv/subnet_address_allocator_top.sv
verif/testbench.sv
